>>> hdl/event_fifo_with_range_extract_defines.svh
// Assertion macros used by the event queue top module.
`ifndef EVENT_FIFO_WITH_RANGE_EXTRACT_DEFINES_SVH
`define EVENT_FIFO_WITH_RANGE_EXTRACT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define EFRE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("event queue assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define EFRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("event queue assertion failed");

`endif

>>> hdl/efre_pkg.sv
`default_nettype none

package efre_pkg;

  // Queue geometry.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned TYPE_W    = 32;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned REQ_W     = 3;

  // Request codes; the two remaining codes are ignored.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH    = 3'd0,
    REQ_POP     = 3'd1,
    REQ_PEEK    = 3'd2,
    REQ_PEEK_RG = 3'd3,
    REQ_EXTRACT = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // One stored event.
  typedef struct packed {
    logic [TYPE_W-1:0]    ev_type;
    logic [PAYLOAD_W-1:0] payload;
  } event_t;

  // Per-cell update control for the execute cycle.
  typedef struct packed {
    logic load;     // take the pushed event
    logic pop;      // take the neighbor's event
    logic extract;  // take the neighbor's event if at or past the match
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/event_fifo_with_range_extract.sv
// Each request is transferred at start while idle, then executed in busy.
// The result strobe done_o rises for one cycle right after the execute cycle; the
// next request can be transferred in that same cycle. No new request is taken while
// busy; the range compare in the cells is registered at the transfer, ahead of the update.
// Reset empties the queue (occupancy zero); stored events are not cleared.
`default_nettype none
`include "event_fifo_with_range_extract_defines.svh"

module event_fifo_with_range_extract (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [2:0]                req_type_i,
  input  wire logic [31:0]               in_event_type_i,
  input  wire logic [63:0]               in_payload_i,
  input  wire logic [31:0]               range_low_i,
  input  wire logic [31:0]               range_high_i,
  output logic                           done_o,
  output logic                           success_o,
  output logic [31:0]                    out_event_type_o,
  output logic [63:0]                    out_payload_o,
  output logic [efre_pkg::CNT_W-1:0]     occupancy_o,
  output logic                           is_empty_o
);
  import efre_pkg::*;

  state_e           state_q, state_d;
  req_e             req_q;
  event_t           push_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;

  event_t           cell_data [DEPTH];
  event_t           cell_next [DEPTH];
  cell_ctl_t        cell_ctl  [DEPTH];
  logic [DEPTH:0]   found;
  logic [DEPTH-1:0] sel;
  logic [DEPTH-1:0] occupied;

  event_t           match_data;
  logic             not_full;
  logic             not_empty;
  logic             do_pop;
  logic             do_push;

  logic             ok_d, ok_q;
  event_t           res_d, res_q;
  logic             done_q;

  assign accept = start & ~busy;
  assign busy   = (state_q == ST_EXEC);

  // Request capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= REQ_CLEAR;
    end else if (accept) begin
      req_q <= req_e'(req_type_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      push_q.ev_type <= in_event_type_i;
      push_q.payload <= in_payload_i;
    end
  end

  assign not_full  = (count_q < CNT_W'(DEPTH));
  assign not_empty = (count_q != '0);
  assign do_pop    = busy && (req_q == REQ_POP) && not_empty;
  assign do_push   = busy && (req_q == REQ_PUSH) && not_full;

  // Row of cells; cell 0 holds the oldest event.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occupied[i]       = (CNT_W'(i) < count_q);
    assign cell_ctl[i].load    = do_push && (count_q[IDX_W-1:0] == IDX_W'(i));
    assign cell_ctl[i].pop     = do_pop;
    assign cell_ctl[i].extract = busy && (req_q == REQ_EXTRACT);

    if (i == DEPTH - 1) begin : g_last
      assign cell_next[i] = cell_data[i];
    end else begin : g_mid
      assign cell_next[i] = cell_data[i+1];
    end

    efre_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cap_i        (accept),
      .range_low_i  (range_low_i),
      .range_high_i (range_high_i),
      .occupied_i   (occupied[i]),
      .found_i      (found[i]),
      .ctl_i        (cell_ctl[i]),
      .push_i       (push_q),
      .next_i       (cell_next[i]),
      .data_o       (cell_data[i]),
      .found_o      (found[i+1]),
      .sel_o        (sel[i])
    );
  end

  // One-hot selection of the matched event.
  always_comb begin
    match_data = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      if (sel[k]) begin
        match_data = match_data | cell_data[k];
      end
    end
  end

  // Execute: next state, count and result.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ok_d    = 1'b0;
    res_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (req_q)
          REQ_PUSH: begin
            if (not_full) begin
              count_d = count_q + CNT_W'(1);
              ok_d    = 1'b1;
            end
          end
          REQ_POP: begin
            if (not_empty) begin
              count_d = count_q - CNT_W'(1);
              ok_d    = 1'b1;
              res_d   = cell_data[0];
            end
          end
          REQ_PEEK: begin
            if (not_empty) begin
              ok_d  = 1'b1;
              res_d = cell_data[0];
            end
          end
          REQ_PEEK_RG: begin
            if (found[DEPTH]) begin
              ok_d  = 1'b1;
              res_d = match_data;
            end
          end
          REQ_EXTRACT: begin
            if (found[DEPTH]) begin
              count_d = count_q - CNT_W'(1);
              ok_d    = 1'b1;
              res_d   = match_data;
            end
          end
          REQ_CLEAR: begin
            count_d = '0;
            ok_d    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= busy;
      if (busy) begin
        ok_q <= ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      res_q <= res_d;
    end
  end

  // Result ports; occupancy reflects the count after the request.
  assign done_o           = done_q;
  assign success_o        = ok_q;
  assign out_event_type_o = res_q.ev_type;
  assign out_payload_o    = res_q.payload;
  assign occupancy_o      = count_q;
  assign is_empty_o       = (count_q == '0);

  // Checks on sequencing and the count.
  `EFRE_ASSERT_NEXT(a_accept_busy, accept, busy && !done_o)
  `EFRE_ASSERT_NEXT(a_exec_done, busy, done_o && !busy)
  `EFRE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
  `EFRE_ASSERT_NEXT(a_push_full, do_push, count_q != '0)

endmodule

`default_nettype wire

>>> hdl/efre_cell.sv
`default_nettype none

module efre_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cap_i,
  input  wire logic [31:0]        range_low_i,
  input  wire logic [31:0]        range_high_i,
  input  wire logic               occupied_i,
  input  wire logic               found_i,
  input  wire efre_pkg::cell_ctl_t ctl_i,
  input  wire efre_pkg::event_t   push_i,
  input  wire efre_pkg::event_t   next_i,
  output efre_pkg::event_t        data_o,
  output logic                    found_o,
  output logic                    sel_o
);
  import efre_pkg::*;

  event_t data_q, data_d;
  logic   hit_q;
  logic   match;
  logic   shift;

  // Range compare against the held event, captured when a request is transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cap_i) begin
      hit_q <= (data_q.ev_type >= range_low_i) && (data_q.ev_type <= range_high_i);
    end
  end

  // Priority chain: the first occupied hit from the head is the selected one.
  assign match   = hit_q & occupied_i;
  assign found_o = found_i | match;
  assign sel_o   = match & ~found_i;

  // A pop moves every cell; an extract closes the gap at and after the match.
  assign shift = ctl_i.pop | (ctl_i.extract & found_o);

  always_comb begin
    if (shift) begin
      data_d = next_i;
    end else if (ctl_i.load) begin
      data_d = push_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import efre_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int CALM_ITEMS    = 300;
  localparam int IDLE_PERCENT  = 35;
  localparam longint TIMEOUT_NS = 4_000_000;

  // Request codes the block ignores.
  localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

  localparam logic [TYPE_W-1:0]    TYPE_MAX    = '1;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX = '1;

  typedef struct packed {
    logic                 success;
    logic [TYPE_W-1:0]    ev_type;
    logic [PAYLOAD_W-1:0] payload;
    logic [CNT_W-1:0]     occupancy;
    logic                 is_empty;
  } queue_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [REQ_W-1:0]     req_type_i;
  logic [TYPE_W-1:0]    in_event_type_i;
  logic [PAYLOAD_W-1:0] in_payload_i;
  logic [TYPE_W-1:0]    range_low_i;
  logic [TYPE_W-1:0]    range_high_i;
  logic                 done_o;
  logic                 success_o;
  logic [TYPE_W-1:0]    out_event_type_o;
  logic [PAYLOAD_W-1:0] out_payload_o;
  logic [CNT_W-1:0]     occupancy_o;
  logic                 is_empty_o;

  // Mirror of the stored events, oldest first, and results still to come.
  event_t        queued_events[$];
  queue_result_t pending_results[$];
  int            error_count;
  bit            idle_on;

  event_fifo_with_range_extract u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .in_event_type_i (in_event_type_i),
    .in_payload_i    (in_payload_i),
    .range_low_i     (range_low_i),
    .range_high_i    (range_high_i),
    .done_o          (done_o),
    .success_o       (success_o),
    .out_event_type_o(out_event_type_o),
    .out_payload_o   (out_payload_o),
    .occupancy_o     (occupancy_o),
    .is_empty_o      (is_empty_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Apply one request to the mirrored queue and return the result it should give.
  function automatic queue_result_t apply_request(logic [REQ_W-1:0] req,
                                                  logic [TYPE_W-1:0] ev_type,
                                                  logic [PAYLOAD_W-1:0] payload,
                                                  logic [TYPE_W-1:0] lo,
                                                  logic [TYPE_W-1:0] hi);
    queue_result_t res;
    event_t        ev;
    int            hit;
    res = '0;
    hit = -1;
    case (req)
      REQ_PUSH: begin
        if (queued_events.size() < DEPTH) begin
          ev.ev_type = ev_type;
          ev.payload = payload;
          queued_events.push_back(ev);
          res.success = 1'b1;
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (queued_events.size() != 0) begin
          res.success = 1'b1;
          res.ev_type = queued_events[0].ev_type;
          res.payload = queued_events[0].payload;
          if (req == REQ_POP) void'(queued_events.pop_front());
        end
      end
      REQ_PEEK_RG, REQ_EXTRACT: begin
        // The oldest event whose type lies within lo..hi, if any.
        foreach (queued_events[i]) begin
          if (hit < 0 && queued_events[i].ev_type >= lo && queued_events[i].ev_type <= hi)
            hit = i;
        end
        if (hit >= 0) begin
          res.success = 1'b1;
          res.ev_type = queued_events[hit].ev_type;
          res.payload = queued_events[hit].payload;
          if (req == REQ_EXTRACT) queued_events.delete(hit);
        end
      end
      REQ_CLEAR: begin
        queued_events.delete();
        res.success = 1'b1;
      end
      default: begin
      end
    endcase
    res.occupancy = CNT_W'(queued_events.size());
    res.is_empty  = (queued_events.size() == 0);
    return res;
  endfunction

  // Send one request; returns at the rising edge that completes the transfer.
  task automatic send_request(logic [REQ_W-1:0] req, logic [TYPE_W-1:0] ev_type,
                              logic [PAYLOAD_W-1:0] payload, logic [TYPE_W-1:0] lo,
                              logic [TYPE_W-1:0] hi);
    while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    req_type_i      <= req;
    in_event_type_i <= ev_type;
    in_payload_i    <= payload;
    range_low_i     <= lo;
    range_high_i    <= hi;
    // Inputs and busy are stable at the falling edge, so the transfer is known there.
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    pending_results.push_back(apply_request(req, ev_type, payload, lo, hi));
    @(posedge clk_i);
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [PAYLOAD_W-1:0] random_payload();
    return {$urandom(), $urandom()};
  endfunction

  task automatic compare_field(string name, logic [PAYLOAD_W-1:0] expected,
                               logic [PAYLOAD_W-1:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, expected, actual);
      error_count++;
    end
  endtask

  // Result checking: each strobed result against the oldest expectation.
  always @(negedge clk_i) begin
    queue_result_t exp_res;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding, occupancy %0d",
                 $realtime, occupancy_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("success", PAYLOAD_W'(exp_res.success), PAYLOAD_W'(success_o));
        compare_field("event type", PAYLOAD_W'(exp_res.ev_type),
                      PAYLOAD_W'(out_event_type_o));
        compare_field("payload", exp_res.payload, out_payload_o);
        compare_field("occupancy", PAYLOAD_W'(exp_res.occupancy), PAYLOAD_W'(occupancy_o));
        compare_field("is_empty", PAYLOAD_W'(exp_res.is_empty), PAYLOAD_W'(is_empty_o));
      end
    end
  end

  // Requests on an empty queue, and a code the block ignores.
  task automatic test_empty_queue();
    send_request(REQ_POP, '0, '0, '0, TYPE_MAX);
    send_request(REQ_PEEK, '0, '0, '0, TYPE_MAX);
    send_request(REQ_EXTRACT, '0, '0, '0, TYPE_MAX);
    send_request(REQ_UNUSED_B, TYPE_MAX, PAYLOAD_MAX, TYPE_MAX, TYPE_MAX);
  endtask

  // Fill to capacity with extreme and mixed values, then push once more.
  task automatic test_fill_to_full();
    logic [TYPE_W-1:0] ev_type;
    for (int i = 0; i <= DEPTH; i++) begin
      ev_type = (i == 0) ? TYPE_MAX : TYPE_W'(i) * 32'h1111_1111;
      send_request(REQ_PUSH, ev_type, (i == 0) ? PAYLOAD_MAX : random_payload(),
                   '0, '0);
    end
  endtask

  // Range matching starting from a full queue: extremes, reversed bounds, then clear.
  task automatic test_range_requests();
    send_request(REQ_PEEK_RG, '0, '0, TYPE_MAX, TYPE_MAX);
    send_request(REQ_EXTRACT, '0, '0, 32'h3000_0000, 32'h5555_5555);
    send_request(REQ_PEEK_RG, '0, '0, 32'h5555_5555, 32'h3000_0000);
    send_request(REQ_PEEK, '0, '0, '0, '0);
    send_request(REQ_CLEAR, '0, '0, '0, '0);
  endtask

  // Random traffic that swings between filling and draining the queue.
  task automatic test_random_traffic();
    logic [REQ_W-1:0]  req;
    logic [TYPE_W-1:0] ev_type;
    logic [TYPE_W-1:0] lo;
    logic [TYPE_W-1:0] hi;
    logic [TYPE_W-1:0] swap;
    int                push_weight;
    int                pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = (n >= CALM_ITEMS);
      case ((n / 100) % 3)
        0:       push_weight = 60;
        1:       push_weight = 15;
        default: push_weight = 35;
      endcase
      // Pause until everything is back now and then.
      if (n % 500 == 499) wait_drained();

      pick = $urandom_range(0, 99);
      if (pick < push_weight) req = REQ_PUSH;
      else if (pick < 97) begin
        case ($urandom_range(0, 3))
          0:       req = REQ_POP;
          1:       req = REQ_PEEK;
          2:       req = REQ_PEEK_RG;
          default: req = REQ_EXTRACT;
        endcase
      end else if (pick < 98) req = REQ_CLEAR;
      else req = $urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B;

      // Types half the time from a small set so that range matches are frequent.
      if ($urandom_range(0, 1)) ev_type = $urandom();
      else begin
        case ($urandom_range(0, 3))
          0:       ev_type = '0;
          1:       ev_type = TYPE_MAX;
          default: ev_type = TYPE_W'($urandom_range(0, 15)) << 24;
        endcase
      end

      // Bounds mostly taken from stored types, otherwise arbitrary or reversed.
      pick = $urandom_range(0, 99);
      if (pick < 70 && queued_events.size() != 0) begin
        lo = queued_events[$urandom_range(0, queued_events.size() - 1)].ev_type;
        hi = ($urandom_range(0, 2) == 0) ? lo
             : queued_events[$urandom_range(0, queued_events.size() - 1)].ev_type;
        if (lo > hi) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
      end else begin
        lo = $urandom();
        hi = $urandom();
      end
      if (pick >= 90 && lo < hi) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end

      send_request(req, ev_type, random_payload(), lo, hi);
    end
  endtask

  // Test sequence.
  initial begin
    error_count     = 0;
    idle_on         = 1'b0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = '0;
    in_event_type_i = '0;
    in_payload_i    = '0;
    range_low_i     = '0;
    range_high_i    = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_to_full();
    test_range_requests();
    wait_drained();
    test_random_traffic();
    wait_drained();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
